// File: rtl/core/fba_pkg.sv
`timescale 1ns / 1ps

package fba_pkg;

  // pool geometry
  localparam int NUM_BLOCKS      = 256;
  localparam int WORD_BYTES      = 8;
  localparam int WORD_SHIFT      = $clog2(WORD_BYTES);
  localparam int MAX_BLOCK_BYTES = 4096;

  // field widths
  localparam int OFF_W  = 20;
  localparam int CNT_W  = 9;
  localparam int SIZE_W = 13;
  localparam int IDX_W  = $clog2(NUM_BLOCKS);

  // configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 13;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = CFG_IDX_W'(1);

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_BAD   = 2'd2
  } status_t;

endpackage

// File: rtl/core/fba_ifs.sv
`timescale 1ns / 1ps

interface fba_req_if;
  logic                          valid;
  logic                          ready;
  fba_pkg::op_t                  op;
  logic [fba_pkg::OFF_W-1:0]     block_offset;

  modport source (output valid, output op, output block_offset, input ready);
  modport sink   (input valid, input op, input block_offset, output ready);
endinterface

interface fba_rsp_if;
  logic                          valid;
  logic                          ready;
  fba_pkg::status_t              status;
  logic [fba_pkg::OFF_W-1:0]     granted_offset;
  logic [fba_pkg::CNT_W-1:0]     free_count;

  modport source (output valid, output status, output granted_offset, output free_count,
                  input ready);
  modport sink   (input valid, input status, input granted_offset, input free_count,
                  output ready);
endinterface

// File: rtl/core/fixed_block_allocator.sv
`timescale 1ns / 1ps

// fixed-size block allocator: hands out and takes back equal blocks of a pool through a
// lifo free list, one request transaction at a time. block k lies at byte offset
// WORD_BYTES + k * size, size being block_bytes clamped to [WORD_BYTES, 4096] and rounded
// up to a word multiple. after reset and after a write to either register the pool is
// rechained (per-entry valid bits stand in for the chain, so there is no clearing pass)
// and the highest block goes out first. an allocate loads the result register after 8
// shift-add steps of the offset multiply and then the finish state; a free loads it
// after 20 restoring-division steps that turn the offset into a block index, then the
// finish state; both run on one shared 21-bit adder. a request that fails early (empty
// pool, offset below the first block) goes straight to the finish state. in_req.ready
// is high only while the block is idle; a finished result waits in the output register,
// and a request whose result register is still held by an unaccepted transaction waits
// in its finish state. the next request is taken as soon as the result register has
// been loaded. bad offsets, blocks past the configured count and frees into a full pool
// report status 2 and leave the list untouched; a double free into a pool that is not
// full is pushed again.
module fixed_block_allocator (
  input  logic                             clk,
  input  logic                             rst_n,
  fba_req_if.sink                          in_req,
  fba_rsp_if.source                        out_rsp,
  input  logic                             cfg_we,
  input  logic [fba_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fba_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int OFF_W  = fba_pkg::OFF_W;
  localparam int CNT_W  = fba_pkg::CNT_W;
  localparam int SIZE_W = fba_pkg::SIZE_W;
  localparam int IDX_W  = fba_pkg::IDX_W;
  localparam int ALU_W  = OFF_W + 1;
  localparam int STEP_W = $clog2(OFF_W + 1);
  localparam int NB     = fba_pkg::NUM_BLOCKS;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_FIN
  } state_t;

  // control and datapath registers
  state_t                    state_r,       state_nxt;
  logic [SIZE_W-1:0]         block_bytes_r, block_bytes_nxt;
  logic [CNT_W-1:0]          block_count_r, block_count_nxt;
  logic [IDX_W-1:0]          head_r,        head_nxt;
  logic [CNT_W-1:0]          free_r,        free_nxt;
  logic [NB-1:0]             vld_r,         vld_nxt;
  logic [STEP_W-1:0]         cnt_r,         cnt_nxt;
  fba_pkg::op_t              op_r,          op_nxt;
  logic                      empty_r,       empty_nxt;
  logic                      pre_ok_r,      pre_ok_nxt;
  logic [OFF_W-1:0]          acc_r,         acc_nxt;
  logic [IDX_W-1:0]          mcand_r,       mcand_nxt;
  logic [OFF_W-1:0]          dvd_r,         dvd_nxt;
  logic [SIZE_W-1:0]         rem_r,         rem_nxt;
  logic [OFF_W-1:0]          quo_r,         quo_nxt;

  // result register
  logic                      out_valid_r,   out_valid_nxt;
  fba_pkg::status_t          out_status_r,  out_status_nxt;
  logic [OFF_W-1:0]          out_granted_r, out_granted_nxt;
  logic [CNT_W-1:0]          out_count_r,   out_count_nxt;

  // link store
  logic [IDX_W-1:0]          link_mem [NB];
  logic [IDX_W-1:0]          link_rd_r;
  logic                      link_rd_vld_r;
  logic                      mem_we;
  logic [IDX_W-1:0]          mem_waddr;
  logic [IDX_W-1:0]          mem_wdata;

  // effective geometry
  logic [SIZE_W-1:0]         size_clamp;
  logic [SIZE_W-1:0]         size_round;
  logic [SIZE_W-1:0]         eff_size;
  logic [CNT_W-1:0]          n_eff;
  logic [IDX_W-1:0]          head_link;

  // shared adder
  logic [ALU_W-1:0]          alu_a;
  logic [ALU_W-1:0]          alu_b;
  logic                      alu_cin;
  logic [ALU_W-1:0]          alu_sum;
  logic [SIZE_W:0]           div_shifted;
  logic                      div_fits;

  logic                      in_fire;
  logic                      load_out;
  logic                      free_ok;

  // block size: clamp, then round up to a word multiple
  always_comb begin
    if (block_bytes_r < SIZE_W'(fba_pkg::WORD_BYTES)) begin
      size_clamp = SIZE_W'(fba_pkg::WORD_BYTES);
    end else if (block_bytes_r > SIZE_W'(fba_pkg::MAX_BLOCK_BYTES)) begin
      size_clamp = SIZE_W'(fba_pkg::MAX_BLOCK_BYTES);
    end else begin
      size_clamp = block_bytes_r;
    end
    size_round = size_clamp + SIZE_W'(fba_pkg::WORD_BYTES - 1);
    eff_size   = {size_round[SIZE_W-1:fba_pkg::WORD_SHIFT], {fba_pkg::WORD_SHIFT{1'b0}}};
  end

  assign n_eff = (block_count_r > CNT_W'(NB)) ? CNT_W'(NB) : block_count_r;

  // an entry never written since the last rechain still holds its walk value
  assign head_link = link_rd_vld_r ? link_rd_r :
                     ((head_r == '0) ? '0 : head_r - IDX_W'(1));

  // one adder serves both the multiply (shift-add) and the divide (trial subtract)
  assign div_shifted = {rem_r, dvd_r[OFF_W-1]};

  always_comb begin
    if (state_r == ST_DIV) begin
      alu_a   = ALU_W'(div_shifted);
      alu_b   = ~ALU_W'(eff_size);
      alu_cin = 1'b1;
    end else begin
      alu_a   = {acc_r, 1'b0};
      alu_b   = mcand_r[IDX_W-1] ? ALU_W'(eff_size) : '0;
      alu_cin = 1'b0;
    end
  end

  assign alu_sum  = alu_a + alu_b + ALU_W'(alu_cin);
  assign div_fits = ~alu_sum[ALU_W-1];

  assign in_fire  = in_req.valid && in_req.ready;
  assign load_out = (state_r == ST_FIN) && (!out_valid_r || out_rsp.ready);
  assign free_ok  = pre_ok_r && (rem_r == '0) && (quo_r < OFF_W'(n_eff)) && (free_r < n_eff);

  always_comb begin
    state_nxt       = state_r;
    block_bytes_nxt = block_bytes_r;
    block_count_nxt = block_count_r;
    head_nxt        = head_r;
    free_nxt        = free_r;
    vld_nxt         = vld_r;
    cnt_nxt         = cnt_r;
    op_nxt          = op_r;
    empty_nxt       = empty_r;
    pre_ok_nxt      = pre_ok_r;
    acc_nxt         = acc_r;
    mcand_nxt       = mcand_r;
    dvd_nxt         = dvd_r;
    rem_nxt         = rem_r;
    quo_nxt         = quo_r;
    out_status_nxt  = out_status_r;
    out_granted_nxt = out_granted_r;
    out_count_nxt   = out_count_r;
    out_valid_nxt   = out_valid_r && !out_rsp.ready;
    mem_we          = 1'b0;
    mem_waddr       = quo_r[IDX_W-1:0];
    mem_wdata       = head_r;

    case (state_r)
      ST_INIT: begin
        // rechain: every entry back to its walk value
        vld_nxt   = '0;
        free_nxt  = n_eff;
        head_nxt  = (n_eff == '0) ? '0 : IDX_W'(n_eff - CNT_W'(1));
        state_nxt = ST_IDLE;
      end

      ST_IDLE: begin
        if (in_fire) begin
          op_nxt  = in_req.op;
          cnt_nxt = '0;
          if (in_req.op == fba_pkg::OP_ALLOC) begin
            empty_nxt = (free_r == '0);
            acc_nxt   = '0;
            mcand_nxt = head_r;
            state_nxt = (free_r == '0) ? ST_FIN : ST_MUL;
          end else begin
            pre_ok_nxt = (in_req.block_offset >= OFF_W'(fba_pkg::WORD_BYTES));
            dvd_nxt    = in_req.block_offset - OFF_W'(fba_pkg::WORD_BYTES);
            rem_nxt    = '0;
            quo_nxt    = '0;
            state_nxt  = (in_req.block_offset >= OFF_W'(fba_pkg::WORD_BYTES)) ?
                         ST_DIV : ST_FIN;
          end
        end
      end

      ST_MUL: begin
        // msb-first shift-add of head index times block size
        acc_nxt   = alu_sum[OFF_W-1:0];
        mcand_nxt = mcand_r << 1;
        cnt_nxt   = cnt_r + STEP_W'(1);
        if (cnt_r == STEP_W'(IDX_W - 1)) begin
          state_nxt = ST_FIN;
        end
      end

      ST_DIV: begin
        // restoring division, one quotient bit a cycle
        rem_nxt   = div_fits ? alu_sum[SIZE_W-1:0] : div_shifted[SIZE_W-1:0];
        quo_nxt   = {quo_r[OFF_W-2:0], div_fits};
        dvd_nxt   = dvd_r << 1;
        cnt_nxt   = cnt_r + STEP_W'(1);
        if (cnt_r == STEP_W'(OFF_W - 1)) begin
          state_nxt = ST_FIN;
        end
      end

      ST_FIN: begin
        if (load_out) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
          if (op_r == fba_pkg::OP_ALLOC) begin
            if (empty_r) begin
              out_status_nxt  = fba_pkg::STATUS_EMPTY;
              out_granted_nxt = '0;
              out_count_nxt   = free_r;
            end else begin
              out_status_nxt  = fba_pkg::STATUS_OK;
              out_granted_nxt = acc_r + OFF_W'(fba_pkg::WORD_BYTES);
              out_count_nxt   = free_r - CNT_W'(1);
              head_nxt        = head_link;
              free_nxt        = free_r - CNT_W'(1);
            end
          end else begin
            out_granted_nxt = '0;
            if (free_ok) begin
              // push the freed block onto the list
              out_status_nxt      = fba_pkg::STATUS_OK;
              out_count_nxt       = free_r + CNT_W'(1);
              mem_we              = 1'b1;
              vld_nxt[mem_waddr]  = 1'b1;
              head_nxt            = quo_r[IDX_W-1:0];
              free_nxt            = free_r + CNT_W'(1);
            end else begin
              out_status_nxt = fba_pkg::STATUS_BAD;
              out_count_nxt  = free_r;
            end
          end
        end
      end

      default: begin
        state_nxt = ST_INIT;
      end
    endcase

    // the user makes register writes only while idle (not enforced); each rechains the pool
    if (cfg_we) begin
      if (cfg_index == fba_pkg::CFG_BLOCK_BYTES) begin
        block_bytes_nxt = cfg_wdata;
        state_nxt       = ST_INIT;
      end else if (cfg_index == fba_pkg::CFG_BLOCK_COUNT) begin
        block_count_nxt = cfg_wdata[CNT_W-1:0];
        state_nxt       = ST_INIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_INIT;
      block_bytes_r <= SIZE_W'(fba_pkg::WORD_BYTES);
      block_count_r <= CNT_W'(NB);
      head_r        <= '0;
      free_r        <= '0;
      vld_r         <= '0;
      cnt_r         <= '0;
      op_r          <= fba_pkg::OP_ALLOC;
      empty_r       <= 1'b0;
      pre_ok_r      <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      block_bytes_r <= block_bytes_nxt;
      block_count_r <= block_count_nxt;
      head_r        <= head_nxt;
      free_r        <= free_nxt;
      vld_r         <= vld_nxt;
      cnt_r         <= cnt_nxt;
      op_r          <= op_nxt;
      empty_r       <= empty_nxt;
      pre_ok_r      <= pre_ok_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    acc_r         <= acc_nxt;
    mcand_r       <= mcand_nxt;
    dvd_r         <= dvd_nxt;
    rem_r         <= rem_nxt;
    quo_r         <= quo_nxt;
    out_status_r  <= out_status_nxt;
    out_granted_r <= out_granted_nxt;
    out_count_r   <= out_count_nxt;
  end

  // link store: one write port, one registered read at the list head
  always_ff @(posedge clk) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= mem_wdata;
    end
    link_rd_r     <= link_mem[head_r];
    link_rd_vld_r <= vld_r[head_r];
  end

  assign in_req.ready           = (state_r == ST_IDLE);
  assign out_rsp.valid          = out_valid_r;
  assign out_rsp.status         = out_status_r;
  assign out_rsp.granted_offset = out_granted_r;
  assign out_rsp.free_count     = out_count_r;

  // free count never exceeds the configured pool
  a_free_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_INIT) |-> (free_r <= n_eff))
    else $error("free count above configured block count");

  // while blocks are free the head names a configured block
  a_head_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r != ST_INIT) && (free_r != '0)) |-> (32'(head_r) < 32'(n_eff)))
    else $error("list head outside configured pool");

  // a result appears only when a request finishes
  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FIN))
    else $error("result transaction without a finished request");

endmodule
